### hdl/plsr_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-length status receiver package
// Shared types and constants: phases, status codes, code lengths and
// register map of the configuration port.
// ----------------------------------------------------------------------------
package plsr_pkg;

	localparam int CFG_W      = 10;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int LEN_W      = 6;

	localparam logic [CFG_W-1:0] OFFSET_RESET   = 10'd100;
	localparam logic [CFG_W-1:0] RESPONSE_RESET = 10'd30;

	// Low times after the offset is removed, one per decodable code.
	localparam logic [LEN_W-1:0] LEN_HOLD       = 6'd5;
	localparam logic [LEN_W-1:0] LEN_DEPARTURE  = 6'd10;
	localparam logic [LEN_W-1:0] LEN_RED_BUFFER = 6'd15;
	localparam logic [LEN_W-1:0] LEN_RED_STOP   = 6'd20;
	localparam logic [LEN_W-1:0] LEN_BOTH_RED   = 6'd25;
	localparam logic [LEN_W-1:0] LEN_YELLOW     = 6'd30;
	localparam logic [LEN_W-1:0] LEN_GREEN      = 6'd35;

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_MEASURE = 2'd1,
		PH_RESPOND = 2'd2,
		PH_HOLD    = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		CODE_NONE         = 4'd0,
		CODE_HOLD         = 4'd1,
		CODE_DEPARTURE    = 4'd2,
		CODE_BOTH_RED     = 4'd3,
		CODE_RED_BUFFER   = 4'd4,
		CODE_RED_STOP     = 4'd5,
		CODE_YELLOW       = 4'd6,
		CODE_GREEN        = 4'd7,
		CODE_UNRECOGNISED = 4'd8
	} code_t;

	typedef enum logic [0:0] {
		REG_PULSE_OFFSET  = 1'b0,
		REG_RESPONSE_TIME = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] pulse_offset;
		logic [CFG_W-1:0] response_time;
	} cfg_t;

	typedef struct packed {
		logic  drive_low;
		logic  peer_buffer_busy;
		logic  peer_stop_busy;
		code_t code_seen;
	} result_t;

endpackage

### hdl/plsr_if.sv
// ----------------------------------------------------------------------------
// Pulse-length status receiver channels
// Valid/ready channels for the tick samples and for the status results.
// ----------------------------------------------------------------------------
interface plsr_in_if;
	logic valid;
	logic ready;
	logic line_level;
	logic local_buffer_busy;
	logic local_stop_busy;

	modport source (output valid, output line_level, output local_buffer_busy,
		output local_stop_busy, input ready);
	modport sink (input valid, input line_level, input local_buffer_busy,
		input local_stop_busy, output ready);
endinterface

interface plsr_out_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       peer_buffer_busy;
	logic       peer_stop_busy;
	logic [3:0] code_seen;

	modport source (output valid, output drive_low, output peer_buffer_busy,
		output peer_stop_busy, output code_seen, input ready);
	modport sink (input valid, input drive_low, input peer_buffer_busy,
		input peer_stop_busy, input code_seen, output ready);
endinterface

### hdl/plsr_cfg.sv
// ----------------------------------------------------------------------------
// Pulse-length status receiver configuration registers
// APB-style register file holding the pulse offset and the response time.
// ----------------------------------------------------------------------------
module plsr_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [plsr_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [plsr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [plsr_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output plsr_pkg::cfg_t                      cfg
);

	plsr_pkg::cfg_t   cfg_q;
	plsr_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = plsr_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_offset  <= plsr_pkg::OFFSET_RESET;
			cfg_q.response_time <= plsr_pkg::RESPONSE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				plsr_pkg::REG_PULSE_OFFSET:  cfg_q.pulse_offset <= pwdata[plsr_pkg::CFG_W-1:0];
				plsr_pkg::REG_RESPONSE_TIME: cfg_q.response_time <= pwdata[plsr_pkg::CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			plsr_pkg::REG_PULSE_OFFSET:  prdata[plsr_pkg::CFG_W-1:0] = cfg_q.pulse_offset;
			plsr_pkg::REG_RESPONSE_TIME: prdata[plsr_pkg::CFG_W-1:0] = cfg_q.response_time;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### hdl/plsr_decode.sv
// ----------------------------------------------------------------------------
// Pulse-length status receiver code decoder
// Removes the offset from the measured low time and matches the code lengths.
// ----------------------------------------------------------------------------
module plsr_decode #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic [COUNT_WIDTH-1:0]        count,
	input  logic [plsr_pkg::CFG_W-1:0]    offset,
	output plsr_pkg::code_t               code
);

	logic [COUNT_WIDTH-1:0] ofs;
	logic [COUNT_WIDTH-1:0] len;

	assign ofs = COUNT_WIDTH'(offset);
	assign len = count - ofs;

	always_comb begin
		code = plsr_pkg::CODE_UNRECOGNISED;
		// A count below the offset never matches any code.
		if (count >= ofs) begin
			if (len == COUNT_WIDTH'(plsr_pkg::LEN_HOLD))
				code = plsr_pkg::CODE_HOLD;
			else if (len == COUNT_WIDTH'(plsr_pkg::LEN_DEPARTURE))
				code = plsr_pkg::CODE_DEPARTURE;
			else if (len == COUNT_WIDTH'(plsr_pkg::LEN_BOTH_RED))
				code = plsr_pkg::CODE_BOTH_RED;
			else if (len == COUNT_WIDTH'(plsr_pkg::LEN_RED_BUFFER))
				code = plsr_pkg::CODE_RED_BUFFER;
			else if (len == COUNT_WIDTH'(plsr_pkg::LEN_RED_STOP))
				code = plsr_pkg::CODE_RED_STOP;
			else if (len == COUNT_WIDTH'(plsr_pkg::LEN_YELLOW))
				code = plsr_pkg::CODE_YELLOW;
			else if (len == COUNT_WIDTH'(plsr_pkg::LEN_GREEN))
				code = plsr_pkg::CODE_GREEN;
		end
	end

endmodule

### hdl/plsr_core.sv
// ----------------------------------------------------------------------------
// Pulse-length status receiver core
// Phase state machine, tick counter and kept flags, advanced once per sample.
// ----------------------------------------------------------------------------
module plsr_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic               line_level,
	input  logic               local_busy,
	input  plsr_pkg::cfg_t     cfg,
	output plsr_pkg::result_t  result
);

	plsr_pkg::phase_t       phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic                   peer_buf_q, peer_buf_d;
	logic                   peer_stop_q, peer_stop_d;
	logic                   drive_q, drive_d;
	plsr_pkg::code_t        match_code, code_d;

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	plsr_decode #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decode (
		.count (elapsed_inc),
		.offset(cfg.pulse_offset),
		.code  (match_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= plsr_pkg::PH_WAIT;
			elapsed_q   <= '0;
			peer_buf_q  <= 1'b0;
			peer_stop_q <= 1'b0;
			drive_q     <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			elapsed_q   <= elapsed_d;
			peer_buf_q  <= peer_buf_d;
			peer_stop_q <= peer_stop_d;
			drive_q     <= drive_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		elapsed_d   = elapsed_q;
		peer_buf_d  = peer_buf_q;
		peer_stop_d = peer_stop_q;
		drive_d     = drive_q;
		code_d      = plsr_pkg::CODE_NONE;
		unique case (phase_q)
			plsr_pkg::PH_WAIT: begin
				if (!line_level) begin
					elapsed_d = '0;
					phase_d   = plsr_pkg::PH_MEASURE;
				end
			end
			plsr_pkg::PH_MEASURE: begin
				elapsed_d = elapsed_inc;
				if (line_level) begin
					code_d = match_code;
					unique case (match_code)
						plsr_pkg::CODE_BOTH_RED: begin
							peer_buf_d  = 1'b1;
							peer_stop_d = 1'b1;
						end
						plsr_pkg::CODE_RED_BUFFER: begin
							peer_buf_d  = 1'b1;
							peer_stop_d = 1'b0;
						end
						plsr_pkg::CODE_RED_STOP: begin
							peer_buf_d  = 1'b0;
							peer_stop_d = 1'b1;
						end
						plsr_pkg::CODE_YELLOW, plsr_pkg::CODE_GREEN: begin
							peer_buf_d  = 1'b0;
							peer_stop_d = 1'b0;
						end
						default: begin
						end
					endcase
					if (match_code == plsr_pkg::CODE_HOLD ||
						match_code == plsr_pkg::CODE_DEPARTURE)
						phase_d = plsr_pkg::PH_RESPOND;
					else
						phase_d = plsr_pkg::PH_WAIT;
				end
			end
			plsr_pkg::PH_RESPOND: begin
				elapsed_d = '0;
				drive_d   = local_busy;
				phase_d   = plsr_pkg::PH_HOLD;
			end
			plsr_pkg::PH_HOLD: begin
				elapsed_d = elapsed_inc;
				// A response time of zero still holds the drive for one tick.
				if (elapsed_inc >= COUNT_WIDTH'(cfg.response_time)) begin
					drive_d = 1'b0;
					phase_d = plsr_pkg::PH_WAIT;
				end
			end
		endcase
	end

	assign result.drive_low        = drive_d;
	assign result.peer_buffer_busy = peer_buf_d;
	assign result.peer_stop_busy   = peer_stop_d;
	assign result.code_seen        = code_d;

	a_drive_only_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q |-> phase_q == plsr_pkg::PH_HOLD)
		else $error("response drive active outside the hold phase");

	a_respond_to_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == plsr_pkg::PH_RESPOND |=> phase_q == plsr_pkg::PH_HOLD)
		else $error("respond phase did not move to hold");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == plsr_pkg::PH_MEASURE && elapsed_q == '1 |=> elapsed_q == '1)
		else $error("tick counter wrapped instead of saturating");

	a_code_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		code_d != plsr_pkg::CODE_NONE |-> phase_q == plsr_pkg::PH_MEASURE && line_level)
		else $error("code reported without a pulse end");

endmodule

### hdl/pulse_length_status_receiver.sv
// ----------------------------------------------------------------------------
// Pulse-length status receiver
// Decodes neighbor status from low-pulse lengths on a shared line and drives
// a response pulse for hold and departure codes if a local sensor is busy.
// ----------------------------------------------------------------------------
// Usage:
//   status carries one sample of the shared line and the two local sensors
//   per tick; result returns one item per sample with the response drive,
//   the kept neighbor occupancy flags and the code decoded on that tick.
//   The APB port holds the pulse offset (address 0) and response time
//   (address 4); write them only while no transfer is in flight.
//   A sample accepted on status lands in the input register, then moves to
//   the result register once that is free or drained, and its result is
//   offered from there. One sample is taken per cycle while result is
//   taken; the core advances its state once per sample it accepts.
//   Reset returns to waiting for a pulse with all flags and the drive
//   cleared and the registers at offset 100 and response time 30.
//   When result is not taken, the result register holds its item and the
//   input register fills; status.ready drops once both are occupied.
// ----------------------------------------------------------------------------
module pulse_length_status_receiver #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	plsr_in_if.sink                           status,
	plsr_out_if.source                        result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [plsr_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [plsr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [plsr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	plsr_pkg::cfg_t    cfg;
	plsr_pkg::result_t step_res;
	plsr_pkg::result_t result_q;
	logic              valid_s1, line_s1, busy_s1;
	logic              result_valid_q;
	logic              advance, step_en;

	plsr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The input stage moves on whenever the result register is free or drained.
	assign advance      = !result_valid_q || result.ready;
	assign step_en      = valid_s1 && advance;
	assign status.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (status.ready)
			valid_s1 <= status.valid;
	end

	always_ff @(posedge clk) begin
		if (status.ready && status.valid) begin
			line_s1 <= status.line_level;
			busy_s1 <= status.local_buffer_busy | status.local_stop_busy;
		end
	end

	plsr_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.line_level(line_s1),
		.local_busy(busy_s1),
		.cfg       (cfg),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (advance)
			result_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step_en)
			result_q <= step_res;
	end

	assign result.valid            = result_valid_q;
	assign result.drive_low        = result_q.drive_low;
	assign result.peer_buffer_busy = result_q.peer_buffer_busy;
	assign result.peer_stop_busy   = result_q.peer_stop_busy;
	assign result.code_seen        = result_q.code_seen;

endmodule
